// File: src/lpcsyn_pkg.sv
// Shared types and constants for the LPC synthesis filter.
package lpcsyn_pkg;

    localparam int MAX_ORDER_DEF = 32;
    localparam int DATA_W        = 32;
    localparam int ORDER_W       = 6;
    localparam int IDX_W         = 5;
    localparam int SAMPLE_W      = 16;
    localparam int FRAC_BITS     = 15;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 6'd16;

    localparam logic signed [DATA_W-1:0] CLIP_POS = 32'sd32766;
    localparam logic signed [DATA_W-1:0] CLIP_NEG = -32'sd32766;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_FILTER = 1'b1;

    typedef struct packed {
        logic                       op;
        logic [IDX_W-1:0]           coef_index;
        logic signed [SAMPLE_W-1:0] coef_value;
        logic signed [SAMPLE_W-1:0] residual_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       clipped;
    } out_item_t;

endpackage

// File: src/lpcsyn_coef_ram.sv
// Predictor coefficient memory: one write port, two registered read ports.
module lpcsyn_coef_ram #(
    parameter int DEPTH = lpcsyn_pkg::MAX_ORDER_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [AW-1:0]                          waddr,
    input  logic signed [lpcsyn_pkg::DATA_W-1:0]   wdata,
    input  logic                                   re,
    input  logic [AW-1:0]                          raddr_a,
    input  logic [AW-1:0]                          raddr_b,
    output logic signed [lpcsyn_pkg::DATA_W-1:0]   rdata_a,
    output logic signed [lpcsyn_pkg::DATA_W-1:0]   rdata_b
);

    logic signed [lpcsyn_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// File: src/lpcsyn_hist_ram.sv
// Output history memory: a circular buffer with one write and one registered read port.
module lpcsyn_hist_ram #(
    parameter int DEPTH = lpcsyn_pkg::MAX_ORDER_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [AW-1:0]                          waddr,
    input  logic signed [lpcsyn_pkg::DATA_W-1:0]   wdata,
    input  logic                                   re,
    input  logic [AW-1:0]                          raddr,
    output logic signed [lpcsyn_pkg::DATA_W-1:0]   rdata
);

    logic signed [lpcsyn_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/lpcsyn_mac.sv
// Shared multiplier: registered 64-bit product, then division by 32768 truncated toward zero.
module lpcsyn_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   valid,
    input  logic signed [lpcsyn_pkg::DATA_W-1:0]   mul_a,
    input  logic signed [lpcsyn_pkg::DATA_W-1:0]   mul_b,
    output logic signed [lpcsyn_pkg::DATA_W-1:0]   quot,
    output logic                                   quot_valid,
    output logic                                   busy
);

    localparam int PW = 2 * lpcsyn_pkg::DATA_W;
    localparam logic signed [PW-1:0] BIAS = (64'sd1 <<< lpcsyn_pkg::FRAC_BITS) - 64'sd1;

    logic signed [PW-1:0] prod_reg;
    logic                 prod_v_reg;
    logic signed [PW-1:0] biased;
    logic signed [lpcsyn_pkg::DATA_W-1:0] quot_reg;
    logic signed [lpcsyn_pkg::DATA_W-1:0] quot_next;
    logic                 quot_v_reg;

    // Adding 2^15 - 1 to a negative product makes the arithmetic shift round toward zero.
    always_comb
    begin
        biased    = prod_reg + (prod_reg[PW-1] ? BIAS : '0);
        quot_next = biased[lpcsyn_pkg::DATA_W+lpcsyn_pkg::FRAC_BITS-1:lpcsyn_pkg::FRAC_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
            quot_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= valid;
            quot_v_reg <= prod_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
        quot_reg <= quot_next;
    end

    assign quot       = quot_reg;
    assign quot_valid = quot_v_reg;
    assign busy       = prod_v_reg | quot_v_reg;

endmodule

// File: src/lpc_synthesis_filter_fixed.sv
// Top level of the fixed-point LPC synthesis filter with step-up coefficient loading.
//
//   Channel  Signals                     Direction  Contents
//   in       in_valid/in_ready/in_data   input      op, coef_index, coef_value, residual_sample
//   out      out_valid/out_ready/out_data output    out_sample, clipped
//   cfg      cfg_wr_en/cfg_wr_data       input      filter_order, written on any rising edge with enable
//
// A sample item issues its taps, waits for the multiplier to drain and then loads its result
// into the output register; the block takes the next item in the cycle after that load. With
// order zero no tap is issued. The shared multiplier handles one tap per cycle, reading
// coefficient and history memories in lockstep. A load item at index n writes its reflection
// value and then runs floor((n + 1) / 2) coefficient pairs, each with the read, two
// multiplies and two write-backs that each coefficient pair needs on the single
// coefficient write port. Reset is asynchronous and active low; it empties the history through
// a fill count, so no clearing pass is needed. The block works on one item at a time; a
// finished result waits in the output register while the next item is accepted, and only a
// second result stalls behind an output that has not been taken.
module lpc_synthesis_filter_fixed #(
    parameter int MAX_ORDER = lpcsyn_pkg::MAX_ORDER_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  lpcsyn_pkg::in_item_t               in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output lpcsyn_pkg::out_item_t              out_data,
    input  logic                               cfg_wr_en,
    input  logic [lpcsyn_pkg::ORDER_W-1:0]     cfg_wr_data
);

    localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int CW = $clog2(MAX_ORDER + 1);
    localparam int DW = lpcsyn_pkg::DATA_W;

    // Controller states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LD_INIT = 4'd1;
    localparam logic [3:0] S_LD_RD   = 4'd2;
    localparam logic [3:0] S_LD_M1   = 4'd3;
    localparam logic [3:0] S_LD_M2   = 4'd4;
    localparam logic [3:0] S_LD_W1   = 4'd5;
    localparam logic [3:0] S_LD_W2   = 4'd6;
    localparam logic [3:0] S_F_RUN   = 4'd7;
    localparam logic [3:0] S_F_DRAIN = 4'd8;
    localparam logic [3:0] S_F_OUT   = 4'd9;

    logic [3:0]    state_reg, state_next;

    // Configuration.
    logic [lpcsyn_pkg::ORDER_W-1:0] filter_order_reg;
    logic [CW-1:0]                  order_eff;

    // Load loop bookkeeping.
    logic [AW-1:0]         n_reg, n_next;
    logic [AW-1:0]         j_reg, j_next;
    logic signed [DW-1:0]  k_reg, k_next;
    logic [AW-1:0]         b_addr;
    logic [CW-1:0]         pairs;

    // Filter loop bookkeeping.
    logic [CW-1:0]         t_cnt_reg, t_cnt_next;
    logic [AW-1:0]         hptr_reg, hptr_next;
    logic [AW-1:0]         head_reg, head_next;
    logic [AW-1:0]         head_inc;
    logic [CW-1:0]         fill_reg, fill_next;
    logic signed [DW-1:0]  acc_reg, acc_next;
    logic                  rd_v_reg, rd_v_next;
    logic                  hv_reg, hv_next;
    logic                  issue;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    lpcsyn_pkg::out_item_t out_data_reg, out_data_next;
    logic                  out_load;
    logic                  out_free;

    // Memory and multiplier connections.
    logic                  coef_we, coef_re;
    logic [AW-1:0]         coef_waddr, coef_raddr_a;
    logic signed [DW-1:0]  coef_wdata, coef_rdata_a, coef_rdata_b;
    logic                  hist_we, hist_re;
    logic signed [DW-1:0]  hist_rdata;
    logic                  mac_valid, mac_quot_valid, mac_busy;
    logic signed [DW-1:0]  mac_a, mac_b, mac_quot;

    lpcsyn_coef_ram #(.DEPTH(MAX_ORDER)) u_coef_ram (
        .clk     (clk),
        .we      (coef_we),
        .waddr   (coef_waddr),
        .wdata   (coef_wdata),
        .re      (coef_re),
        .raddr_a (coef_raddr_a),
        .raddr_b (b_addr),
        .rdata_a (coef_rdata_a),
        .rdata_b (coef_rdata_b)
    );

    lpcsyn_hist_ram #(.DEPTH(MAX_ORDER)) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (head_inc),
        .wdata (acc_reg),
        .re    (hist_re),
        .raddr (hptr_reg),
        .rdata (hist_rdata)
    );

    lpcsyn_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (mac_valid),
        .mul_a      (mac_a),
        .mul_b      (mac_b),
        .quot       (mac_quot),
        .quot_valid (mac_quot_valid),
        .busy       (mac_busy)
    );

    // The configured order saturates at the depth of the stores.
    always_comb
    begin
        if (int'(filter_order_reg) > MAX_ORDER)
        begin
            order_eff = CW'(MAX_ORDER);
        end
        else
        begin
            order_eff = CW'(filter_order_reg);
        end
    end

    // Step n of the recursion touches pairs (j, n-1-j) for j below (n+1)/2.
    assign pairs    = CW'((CW'(n_reg) + CW'(1)) >> 1);
    assign b_addr   = n_reg - AW'(1) - j_reg;
    assign head_inc = (head_reg == AW'(MAX_ORDER - 1)) ? '0 : head_reg + AW'(1);
    assign issue    = (state_reg == S_F_RUN) && (t_cnt_reg < order_eff);
    assign out_free = !out_valid_reg || out_ready;

    // Memory reads: one coefficient pair per load step, or one tap per cycle while filtering.
    assign coef_re      = (state_reg == S_LD_RD) || issue;
    assign coef_raddr_a = (state_reg == S_F_RUN) ? t_cnt_reg[AW-1:0] : j_reg;
    assign hist_re      = issue;

    // The coefficient write port serves the new reflection value and both halves of a pair.
    always_comb
    begin
        coef_we    = 1'b0;
        coef_waddr = n_reg;
        coef_wdata = k_reg;
        case (state_reg)
            S_LD_INIT:
            begin
                coef_we    = 1'b1;
                coef_waddr = n_reg;
                coef_wdata = k_reg;
            end
            S_LD_W1:
            begin
                coef_we    = 1'b1;
                coef_waddr = j_reg;
                coef_wdata = coef_rdata_a - mac_quot;
            end
            S_LD_W2:
            begin
                coef_we    = 1'b1;
                coef_waddr = b_addr;
                coef_wdata = coef_rdata_b - mac_quot;
            end
            default:
            begin
                coef_we = 1'b0;
            end
        endcase
    end

    // Multiplier operands. History taps that were never filled since reset count as zero.
    always_comb
    begin
        mac_valid = (state_reg == S_LD_M1) || (state_reg == S_LD_M2) || rd_v_reg;
        if (rd_v_reg)
        begin
            mac_a = coef_rdata_a;
            mac_b = hv_reg ? hist_rdata : '0;
        end
        else if (state_reg == S_LD_M1)
        begin
            mac_a = coef_rdata_b;
            mac_b = k_reg;
        end
        else
        begin
            mac_a = coef_rdata_a;
            mac_b = k_reg;
        end
    end

    // Main controller.
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        t_cnt_next     = t_cnt_reg;
        hptr_next      = hptr_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        acc_next       = acc_reg;
        rd_v_next      = 1'b0;
        hv_next        = hv_reg;
        hist_we        = 1'b0;
        out_load       = 1'b0;
        in_ready       = (state_reg == S_IDLE);

        // Quotients of filter taps come back through the product and quotient registers of the multiplier.
        if (((state_reg == S_F_RUN) || (state_reg == S_F_DRAIN)) && mac_quot_valid)
        begin
            acc_next = acc_reg + mac_quot;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.op == lpcsyn_pkg::OP_FILTER)
                    begin
                        acc_next   = DW'(in_data.residual_sample);
                        t_cnt_next = '0;
                        hptr_next  = head_reg;
                        state_next = S_F_RUN;
                    end
                    else if (int'(in_data.coef_index) < MAX_ORDER)
                    begin
                        n_next     = AW'(in_data.coef_index);
                        k_next     = DW'(in_data.coef_value);
                        j_next     = '0;
                        state_next = S_LD_INIT;
                    end
                end
            end
            S_LD_INIT:
            begin
                state_next = (pairs != '0) ? S_LD_RD : S_IDLE;
            end
            S_LD_RD:
            begin
                state_next = S_LD_M1;
            end
            S_LD_M1:
            begin
                state_next = S_LD_M2;
            end
            S_LD_M2:
            begin
                state_next = S_LD_W1;
            end
            S_LD_W1:
            begin
                state_next = S_LD_W2;
            end
            S_LD_W2:
            begin
                j_next = j_reg + AW'(1);
                if ((CW'(j_reg) + CW'(1)) < pairs)
                begin
                    state_next = S_LD_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_F_RUN:
            begin
                if (issue)
                begin
                    t_cnt_next = t_cnt_reg + CW'(1);
                    hptr_next  = (hptr_reg == '0) ? AW'(MAX_ORDER - 1) : hptr_reg - AW'(1);
                    rd_v_next  = 1'b1;
                    hv_next    = (t_cnt_reg < fill_reg);
                end
                else
                begin
                    state_next = S_F_DRAIN;
                end
            end
            S_F_DRAIN:
            begin
                if (!rd_v_reg && !mac_busy)
                begin
                    state_next = S_F_OUT;
                end
            end
            S_F_OUT:
            begin
                if (out_free)
                begin
                    hist_we    = 1'b1;
                    head_next  = head_inc;
                    if (fill_reg < CW'(MAX_ORDER))
                    begin
                        fill_next = fill_reg + CW'(1);
                    end
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Clipping of the unclipped filter value into the emitted sample.
    always_comb
    begin
        out_data_next = out_data_reg;
        if (acc_reg > lpcsyn_pkg::CLIP_POS)
        begin
            out_data_next.out_sample = lpcsyn_pkg::CLIP_POS[lpcsyn_pkg::SAMPLE_W-1:0];
            out_data_next.clipped    = 1'b1;
        end
        else if (acc_reg < lpcsyn_pkg::CLIP_NEG)
        begin
            out_data_next.out_sample = lpcsyn_pkg::CLIP_NEG[lpcsyn_pkg::SAMPLE_W-1:0];
            out_data_next.clipped    = 1'b1;
        end
        else
        begin
            out_data_next.out_sample = acc_reg[lpcsyn_pkg::SAMPLE_W-1:0];
            out_data_next.clipped    = 1'b0;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            filter_order_reg <= lpcsyn_pkg::ORDER_RESET;
            head_reg         <= '0;
            fill_reg         <= '0;
            rd_v_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            t_cnt_reg        <= '0;
            j_reg            <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            rd_v_reg      <= rd_v_next;
            out_valid_reg <= out_valid_next;
            t_cnt_reg     <= t_cnt_next;
            j_reg         <= j_next;
            if (cfg_wr_en)
            begin
                filter_order_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        k_reg    <= k_next;
        hptr_reg <= hptr_next;
        acc_reg  <= acc_next;
        hv_reg   <= hv_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
